[hdl/sfce_pkg.sv]
// Package for the SPI flash command engine: state codes, opcodes, word types.
// No dependencies.
package sfce_pkg;

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_STAT_CMD = 5'd1;
    localparam logic [4:0] ST_STAT_RX  = 5'd2;
    localparam logic [4:0] ST_RDY_CMD  = 5'd3;
    localparam logic [4:0] ST_RDY_RX   = 5'd4;
    localparam logic [4:0] ST_GAP1     = 5'd5;
    localparam logic [4:0] ST_RD_CMD   = 5'd6;
    localparam logic [4:0] ST_A2       = 5'd7;
    localparam logic [4:0] ST_A1       = 5'd8;
    localparam logic [4:0] ST_A0       = 5'd9;
    localparam logic [4:0] ST_RD_RX    = 5'd10;
    localparam logic [4:0] ST_WREN     = 5'd11;
    localparam logic [4:0] ST_GAP2     = 5'd12;
    localparam logic [4:0] ST_ER_CMD   = 5'd13;
    localparam logic [4:0] ST_GAP3     = 5'd14;
    localparam logic [4:0] ST_POLL_CMD = 5'd15;
    localparam logic [4:0] ST_POLL_RX  = 5'd16;
    localparam logic [4:0] ST_RES_CMD  = 5'd17;
    localparam logic [4:0] ST_GAP4     = 5'd18;

    localparam logic [2:0] OP_STATUS = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_RUN    = 3'd2;
    localparam logic [2:0] OP_ERASE  = 3'd3;
    localparam logic [2:0] OP_RESUME = 3'd4;
    localparam logic [2:0] OP_CRC    = 3'd5;

    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_ER4K  = 8'h20;
    localparam logic [7:0] CMD_ER32K = 8'h52;
    localparam logic [7:0] CMD_ER64K = 8'hD8;
    localparam logic [7:0] CMD_RES   = 8'hAB;

    typedef struct packed {
        logic        kind;
        logic [2:0]  op;
        logic [23:0] address;
        logic [19:0] byte_count;
        logic [23:0] end_address;
        logic [1:0]  erase_size;
        logic        wait_done;
        logic        miso;
    } t_in_word;

    typedef struct packed {
        logic        cs_n;
        logic        sck_pulse;
        logic        mosi;
        logic        busy_res;
        logic        done_res;
        logic        ok;
        logic        data_valid;
        logic [7:0]  data;
        logic [15:0] crc;
    } t_out_word;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = {c_in[7:0], c_in[15:8]};
        c = c ^ {8'd0, b};
        c = c ^ {12'd0, c[7:4]};
        c = c ^ {c[3:0], 12'd0};
        c = c ^ {3'd0, c[7:0], 5'd0};
        return c;
    endfunction

endpackage

[hdl/sfce_if.sv]
// Valid/ready channel carrying one word of type T.
// No dependencies; the word type is the parameter T.
interface sfce_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/sfce_seq.sv]
// Command sequencer: state registers and next-word logic for one input word.
// Depends on sfce_pkg.
module sfce_seq #(
    parameter int FLASH_BYTES = 524288
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  sfce_pkg::t_in_word  i_word,
    output sfce_pkg::t_out_word o_word
);
    import sfce_pkg::*;

    localparam logic [24:0] LIMIT = 25'(FLASH_BYTES);

    logic [4:0]  r_state, n_state;
    logic [7:0]  r_shift, n_shift;
    logic [2:0]  r_bit, n_bit;
    logic [23:0] r_addr, n_addr;
    logic [23:0] r_stop, n_stop;
    logic [19:0] r_left, n_left;
    logic [15:0] r_crc, n_crc;
    logic [2:0]  r_op, n_op;
    logic [7:0]  r_eop, n_eop;
    logic        r_poll, n_poll;

    logic        gap, rx;
    logic [7:0]  tx;
    logic [7:0]  b;
    logic [23:0] addr_inc;
    logic [19:0] left_dec;
    logic [15:0] crc_next;
    t_out_word   w;

    always_comb begin
        gap = (r_state == ST_GAP1) || (r_state == ST_GAP2) ||
              (r_state == ST_GAP3) || (r_state == ST_GAP4);
        rx  = (r_state == ST_STAT_RX) || (r_state == ST_RDY_RX) ||
              (r_state == ST_RD_RX) || (r_state == ST_POLL_RX);
        case (r_state)
            ST_STAT_CMD, ST_RDY_CMD, ST_POLL_CMD: tx = CMD_RDSR;
            ST_RD_CMD:  tx = CMD_READ;
            ST_A2:      tx = r_addr[23:16];
            ST_A1:      tx = r_addr[15:8];
            ST_A0:      tx = r_addr[7:0];
            ST_WREN:    tx = CMD_WREN;
            ST_ER_CMD:  tx = r_eop;
            ST_RES_CMD: tx = CMD_RES;
            default:    tx = 8'd0;
        endcase
        b        = {r_shift[6:0], i_word.miso};
        addr_inc = r_addr + 24'd1;
        left_dec = r_left - 20'd1;
        crc_next = crc_byte(r_crc, b);
    end

    always_comb begin
        n_state = r_state; n_shift = r_shift; n_bit = r_bit; n_addr = r_addr;
        n_stop = r_stop; n_left = r_left; n_crc = r_crc; n_op = r_op;
        n_eop = r_eop; n_poll = r_poll;
        w = '0;
        w.cs_n = 1'b1;
        if (!i_word.kind) begin
            if (r_state == ST_IDLE) begin
                n_op   = i_word.op;
                n_addr = i_word.address;
                n_bit  = 3'd0;
                case (i_word.op)
                    OP_STATUS: n_state = ST_STAT_CMD;
                    OP_READ:   n_state = ST_RDY_CMD;
                    OP_RUN: begin
                        if ({1'b0, i_word.address} > LIMIT) begin
                            w.done_res = 1'b1;
                        end else begin
                            n_left  = i_word.byte_count;
                            n_state = ST_RDY_CMD;
                        end
                    end
                    OP_ERASE: begin
                        case (i_word.erase_size)
                            2'd0: n_eop = CMD_ER4K;
                            2'd1: n_eop = CMD_ER32K;
                            default: n_eop = CMD_ER64K;
                        endcase
                        if (i_word.erase_size == 2'd3) begin
                            w.done_res = 1'b1;
                        end else begin
                            n_poll  = i_word.wait_done;
                            n_state = ST_RDY_CMD;
                        end
                    end
                    OP_RESUME: n_state = ST_RES_CMD;
                    OP_CRC: begin
                        n_stop = i_word.end_address;
                        n_crc  = 16'd0;
                        if (i_word.address >= i_word.end_address) begin
                            w.done_res = 1'b1;
                            w.ok       = 1'b1;
                        end else begin
                            n_state = ST_RDY_CMD;
                        end
                    end
                    default: w.done_res = 1'b1;
                endcase
                if (i_word.op == OP_ERASE && i_word.erase_size == 2'd3) n_eop = r_eop;
                w.cs_n = (n_state == ST_IDLE);
            end else begin
                w.cs_n = gap;
            end
        end else if (r_state == ST_IDLE) begin
            w.cs_n = 1'b1;
        end else if (gap) begin
            n_bit = 3'd0;
            case (r_state)
                ST_GAP1: n_state = (r_op == OP_ERASE) ? ST_WREN : ST_RD_CMD;
                ST_GAP2: n_state = ST_ER_CMD;
                ST_GAP3: n_state = ST_POLL_CMD;
                default: n_state = ST_RDY_CMD;
            endcase
        end else begin
            w.cs_n      = 1'b0;
            w.sck_pulse = 1'b1;
            if (rx) n_shift = b;
            else    w.mosi = tx[3'd7 - r_bit];
            n_bit = r_bit + 3'd1;
            if (r_bit == 3'd7) begin
                case (r_state)
                    ST_STAT_CMD: n_state = ST_STAT_RX;
                    ST_STAT_RX: begin
                        w.data_valid = 1'b1; w.data = b;
                        n_state = ST_IDLE; w.done_res = 1'b1; w.ok = 1'b1;
                    end
                    ST_RDY_CMD: n_state = ST_RDY_RX;
                    ST_RDY_RX: begin
                        if (b[0]) begin
                            n_state = ST_IDLE; w.done_res = 1'b1;
                        end else begin
                            n_state = ST_GAP1;
                        end
                    end
                    ST_RD_CMD, ST_ER_CMD: n_state = ST_A2;
                    ST_A2: n_state = ST_A1;
                    ST_A1: n_state = ST_A0;
                    ST_A0: begin
                        if (r_op == OP_ERASE) begin
                            if (r_poll) n_state = ST_GAP3;
                            else begin
                                n_state = ST_IDLE; w.done_res = 1'b1; w.ok = 1'b1;
                            end
                        end else if (r_op == OP_RUN && r_left == 20'd0) begin
                            n_state = ST_IDLE; w.done_res = 1'b1; w.ok = 1'b1;
                        end else begin
                            n_state = ST_RD_RX;
                        end
                    end
                    ST_RD_RX: begin
                        if (r_op == OP_READ) begin
                            w.data_valid = 1'b1; w.data = b;
                            n_state = ST_IDLE; w.done_res = 1'b1; w.ok = 1'b1;
                        end else if (r_op == OP_RUN) begin
                            w.data_valid = 1'b1; w.data = b;
                            n_left = left_dec;
                            if (left_dec == 20'd0) begin
                                n_state = ST_IDLE; w.done_res = 1'b1; w.ok = 1'b1;
                            end
                        end else if (r_op == OP_CRC) begin
                            n_crc  = crc_next;
                            n_addr = addr_inc;
                            if (addr_inc >= r_stop) begin
                                n_state = ST_IDLE; w.done_res = 1'b1; w.ok = 1'b1;
                                w.crc = crc_next;
                            end else begin
                                n_state = ST_GAP4;
                            end
                        end else begin
                            n_state = ST_IDLE; w.done_res = 1'b1;
                        end
                    end
                    ST_WREN: n_state = ST_GAP2;
                    ST_POLL_CMD: n_state = ST_POLL_RX;
                    ST_POLL_RX: begin
                        if (!b[0]) begin
                            n_state = ST_IDLE; w.done_res = 1'b1; w.ok = 1'b1;
                        end
                    end
                    ST_RES_CMD: begin
                        n_state = ST_IDLE; w.done_res = 1'b1; w.ok = 1'b1;
                    end
                    default: begin
                        n_state = ST_IDLE; w.done_res = 1'b1;
                    end
                endcase
            end
        end
        if (!i_word.kind && r_state == ST_IDLE && w.done_res && i_word.op == OP_CRC &&
            w.ok) begin
            w.crc = 16'd0;
        end
        w.busy_res = (n_state != ST_IDLE);
        o_word = w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_shift <= '0; r_bit <= '0; r_addr <= '0;
            r_stop <= '0; r_left <= '0; r_crc <= '0; r_op <= '0;
            r_eop <= '0; r_poll <= 1'b0;
        end else if (i_step) begin
            r_state <= n_state; r_shift <= n_shift; r_bit <= n_bit; r_addr <= n_addr;
            r_stop <= n_stop; r_left <= n_left; r_crc <= n_crc; r_op <= n_op;
            r_eop <= n_eop; r_poll <= n_poll;
        end
    end
endmodule

[hdl/spi_flash_command_engine_unit.sv]
// Top level of the SPI flash command engine: input register, sequencer, result register.
// Depends on sfce_pkg, sfce_if and sfce_seq.
// Each result word is the sequencer output for the held input word, registered on a step.
// Throughput: one word per cycle; the input and result registers keep the
// sequencer stepping while the result side has space.
// Reset: synchronous active-low i_rst_n; sequencer idle, both registers empty.
module spi_flash_command_engine_unit #(
    parameter int FLASH_BYTES = 524288
) (
    input logic  i_clk,
    input logic  i_rst_n,
    sfce_if.sink   i_in,
    sfce_if.source o_out
);
    import sfce_pkg::*;

    logic      r_in_vld;
    t_in_word  r_in;
    logic      r_out_vld;
    t_out_word r_out;
    t_out_word seq_word;
    logic      step;

    assign step       = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || step;
    assign o_out.valid   = r_out_vld;
    assign o_out.payload = r_out;

    sfce_seq #(.FLASH_BYTES(FLASH_BYTES)) u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (step),
        .i_word (r_in),
        .o_word (seq_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.ready) r_in_vld <= i_in.valid;
            if (step) r_out_vld <= 1'b1;
            else if (o_out.ready) r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) r_in <= i_in.payload;
        if (step) r_out <= seq_word;
    end
endmodule

[test/tb.sv]
// Testbench for spi_flash_command_engine_unit: drives command and bit-tick words,
// predicts every result word with a behavioral model of the sequencer and checks it.
// Depends on sfce_pkg, sfce_if and the engine RTL.
`timescale 1ns / 100ps

module tb;
    import sfce_pkg::*;

    localparam int FLASH_SIZE = 524288;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 430;

    logic i_clk;
    logic i_rst_n;

    sfce_if #(.T(t_in_word))  in_ch();
    sfce_if #(.T(t_out_word)) out_ch();

    spi_flash_command_engine_unit #(.FLASH_BYTES(FLASH_SIZE)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    logic [4:0]  seq_st;
    logic [7:0]  rx_byte;
    logic [2:0]  bit_pos;
    logic [23:0] cur_addr;
    logic [23:0] stop_addr;
    logic [19:0] run_left;
    logic [15:0] crc_acc;
    logic [2:0]  cur_op;
    logic [7:0]  er_code;
    logic        er_poll;

    t_out_word expected_words[$];
    int        mismatches;
    int        cycles;
    int        hold_off;
    int        sent_count;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic [15:0] fold_crc(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = {c_in[7:0], c_in[15:8]} ^ {8'd0, b};
        c = c ^ {12'd0, c[7:4]};
        c = c ^ {c[3:0], 12'd0};
        c = c ^ {3'd0, c[7:0], 5'd0};
        return c;
    endfunction

    function automatic logic [7:0] tx_value();
        case (seq_st)
            ST_STAT_CMD, ST_RDY_CMD, ST_POLL_CMD: return CMD_RDSR;
            ST_RD_CMD:  return CMD_READ;
            ST_A2:      return cur_addr[23:16];
            ST_A1:      return cur_addr[15:8];
            ST_A0:      return cur_addr[7:0];
            ST_WREN:    return CMD_WREN;
            ST_ER_CMD:  return er_code;
            ST_RES_CMD: return CMD_RES;
            default:    return 8'h00;
        endcase
    endfunction

    function automatic void end_op(input logic good, inout t_out_word r);
        seq_st = ST_IDLE;
        r.done_res = 1'b1;
        r.ok = good;
        if (good && cur_op == OP_CRC) r.crc = crc_acc;
    endfunction

    function automatic void byte_done(inout t_out_word r);
        case (seq_st)
            ST_STAT_CMD: seq_st = ST_STAT_RX;
            ST_STAT_RX: begin
                r.data_valid = 1'b1; r.data = rx_byte; end_op(1'b1, r);
            end
            ST_RDY_CMD: seq_st = ST_RDY_RX;
            ST_RDY_RX: begin
                if (rx_byte[0]) end_op(1'b0, r);
                else seq_st = ST_GAP1;
            end
            ST_RD_CMD, ST_ER_CMD: seq_st = ST_A2;
            ST_A2: seq_st = ST_A1;
            ST_A1: seq_st = ST_A0;
            ST_A0: begin
                if (cur_op == OP_ERASE) begin
                    if (er_poll) seq_st = ST_GAP3;
                    else end_op(1'b1, r);
                end else if (cur_op == OP_RUN && run_left == 20'd0) begin
                    end_op(1'b1, r);
                end else begin
                    seq_st = ST_RD_RX;
                end
            end
            ST_RD_RX: begin
                if (cur_op == OP_READ) begin
                    r.data_valid = 1'b1; r.data = rx_byte; end_op(1'b1, r);
                end else if (cur_op == OP_RUN) begin
                    r.data_valid = 1'b1; r.data = rx_byte;
                    run_left = run_left - 20'd1;
                    if (run_left == 20'd0) end_op(1'b1, r);
                end else if (cur_op == OP_CRC) begin
                    crc_acc = fold_crc(crc_acc, rx_byte);
                    cur_addr = cur_addr + 24'd1;
                    if (cur_addr >= stop_addr) end_op(1'b1, r);
                    else seq_st = ST_GAP4;
                end else begin
                    end_op(1'b0, r);
                end
            end
            ST_WREN: seq_st = ST_GAP2;
            ST_POLL_CMD: seq_st = ST_POLL_RX;
            ST_POLL_RX: begin
                if (!rx_byte[0]) end_op(1'b1, r);
            end
            ST_RES_CMD: end_op(1'b1, r);
            default: end_op(1'b0, r);
        endcase
    endfunction

    function automatic void start_cmd(input t_in_word w, inout t_out_word r);
        cur_op = w.op;
        cur_addr = w.address;
        bit_pos = 3'd0;
        case (w.op)
            OP_STATUS: seq_st = ST_STAT_CMD;
            OP_READ:   seq_st = ST_RDY_CMD;
            OP_RUN: begin
                if ({8'd0, w.address} > 32'(FLASH_SIZE)) end_op(1'b0, r);
                else begin
                    run_left = w.byte_count;
                    seq_st = ST_RDY_CMD;
                end
            end
            OP_ERASE: begin
                if (w.erase_size == 2'd3) end_op(1'b0, r);
                else begin
                    er_code = (w.erase_size == 2'd0) ? CMD_ER4K :
                              (w.erase_size == 2'd1) ? CMD_ER32K : CMD_ER64K;
                    er_poll = w.wait_done;
                    seq_st = ST_RDY_CMD;
                end
            end
            OP_RESUME: seq_st = ST_RES_CMD;
            OP_CRC: begin
                stop_addr = w.end_address;
                crc_acc = 16'd0;
                if (w.address >= w.end_address) end_op(1'b1, r);
                else seq_st = ST_RDY_CMD;
            end
            default: end_op(1'b0, r);
        endcase
    endfunction

    function automatic logic in_gap(input logic [4:0] s);
        return s == ST_GAP1 || s == ST_GAP2 || s == ST_GAP3 || s == ST_GAP4;
    endfunction

    function automatic t_out_word predict_pins(input t_in_word w);
        t_out_word r;
        logic [2:0] bi;
        logic [7:0] tx;
        r = '0;
        r.cs_n = 1'b1;
        if (!w.kind) begin
            if (seq_st == ST_IDLE) start_cmd(w, r);
            r.cs_n = (seq_st == ST_IDLE || in_gap(seq_st));
        end else if (seq_st == ST_IDLE) begin
            r.cs_n = 1'b1;
        end else if (in_gap(seq_st)) begin
            bit_pos = 3'd0;
            case (seq_st)
                ST_GAP1: seq_st = (cur_op == OP_ERASE) ? ST_WREN : ST_RD_CMD;
                ST_GAP2: seq_st = ST_ER_CMD;
                ST_GAP3: seq_st = ST_POLL_CMD;
                default: seq_st = ST_RDY_CMD;
            endcase
        end else begin
            bi = bit_pos;
            r.cs_n = 1'b0;
            r.sck_pulse = 1'b1;
            if (seq_st == ST_STAT_RX || seq_st == ST_RDY_RX || seq_st == ST_RD_RX ||
                seq_st == ST_POLL_RX) begin
                rx_byte = {rx_byte[6:0], w.miso};
            end else begin
                tx = tx_value();
                r.mosi = tx[3'd7 - bi];
            end
            bit_pos = bi + 3'd1;
            if (bi == 3'd7) byte_done(r);
        end
        r.busy_res = (seq_st != ST_IDLE);
        return r;
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_words.push_back(predict_pins(w));
        sent_count++;
    endtask

    initial begin
        t_out_word got, exp_w;
        int        wait_left;
        out_ch.ready = 1'b0;
        mismatches = 0;
        wait_left = 0;
        @(posedge i_clk);
        forever begin
            if (hold_off > 0) begin
                out_ch.ready <= 1'b0;
                hold_off--;
            end else if (wait_left > 0) begin
                out_ch.ready <= 1'b0;
                wait_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got = out_ch.payload;
                wait_left = $urandom_range(0, 6);
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h", got);
                end else begin
                    exp_w = expected_words.pop_front();
                    if (got !== exp_w) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h actual %h", exp_w, got);
                    end
                end
            end
        end
    end

    function automatic t_in_word cmd_word(input logic [2:0] op, input logic [23:0] a,
                                          input logic [19:0] n, input logic [23:0] e,
                                          input logic [1:0] sz, input logic wd);
        t_in_word w;
        w = '0;
        w.op = op; w.address = a; w.byte_count = n; w.end_address = e;
        w.erase_size = sz; w.wait_done = wd;
        w.miso = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // flash reply bit: ready checks mostly pass, poll stays busy for a while
    function automatic logic flash_bit();
        if ((seq_st == ST_RDY_RX || seq_st == ST_POLL_RX) && bit_pos == 3'd7) begin
            if (seq_st == ST_RDY_RX) return ($urandom_range(0, 9) == 0);
            return ($urandom_range(0, 2) != 0);
        end
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic tick_word();
        t_in_word w;
        w.kind        = 1'b1;
        w.op          = 3'($urandom);
        w.address     = 24'($urandom);
        w.byte_count  = 20'($urandom);
        w.end_address = 24'($urandom);
        w.erase_size  = 2'($urandom);
        w.wait_done   = 1'($urandom);
        w.miso        = flash_bit();
        send_word(w);
    endtask

    task automatic run_command(input t_in_word w, input int max_ticks);
        int n;
        send_word(w);
        n = 0;
        while (seq_st != ST_IDLE && n < max_ticks) begin
            if ($urandom_range(0, 15) == 0) begin
                w.address = 24'($urandom);
                send_word(w);
            end else begin
                tick_word();
            end
            n++;
        end
        while (seq_st != ST_IDLE) tick_word();
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_directed();
        t_in_word w;
        w = '0; w.kind = 1'b1; w.miso = 1'b1;
        send_word(w);
        run_command(cmd_word(OP_STATUS, 24'hFFFFFF, 20'hFFFFF, 24'hFFFFFF, 2'd3, 1'b1), 100);
        run_command(cmd_word(OP_READ, 24'hFFFFFF, 20'd0, 24'd0, 2'd0, 1'b0), 100);
        run_command(cmd_word(OP_RUN, 24'hFFFFFF, 20'd5, 24'd0, 2'd0, 1'b0), 100);
        run_command(cmd_word(OP_RUN, 24'(FLASH_SIZE), 20'd0, 24'd0, 2'd0, 1'b0), 200);
        run_command(cmd_word(OP_RUN, 24'(FLASH_SIZE + 1), 20'd2, 24'd0, 2'd0, 1'b0), 200);
        run_command(cmd_word(OP_ERASE, 24'h123456, 20'd0, 24'd0, 2'd0, 1'b0), 200);
        run_command(cmd_word(OP_ERASE, 24'hABCDEF, 20'd0, 24'd0, 2'd1, 1'b1), 400);
        run_command(cmd_word(OP_ERASE, 24'h00FF00, 20'd0, 24'd0, 2'd2, 1'b0), 400);
        run_command(cmd_word(OP_ERASE, 24'h00FF00, 20'd0, 24'd0, 2'd3, 1'b1), 400);
        run_command(cmd_word(OP_RESUME, 24'd0, 20'd0, 24'd0, 2'd0, 1'b0), 100);
        run_command(cmd_word(OP_CRC, 24'h000010, 20'd0, 24'h000010, 2'd0, 1'b0), 100);
        run_command(cmd_word(OP_CRC, 24'hFFFFFE, 20'd0, 24'hFFFFFF, 2'd0, 1'b0), 400);
        run_command(cmd_word(3'd6, 24'd0, 20'd0, 24'd0, 2'd0, 1'b0), 10);
        run_command(cmd_word(3'd7, 24'd0, 20'd0, 24'd0, 2'd0, 1'b0), 10);
        drain();
    endtask

    task automatic test_random();
        t_in_word w;
        int       k;
        k = 0;
        while (k < 3 || sent_count < ITEM_TARGET) begin
            w.kind        = 1'b0;
            w.op          = 3'($urandom);
            w.address     = 24'($urandom);
            w.end_address = w.address + 24'($urandom_range(0, 3));
            w.byte_count  = 20'($urandom_range(0, 4));
            w.erase_size  = 2'($urandom);
            w.wait_done   = 1'($urandom);
            w.miso        = 1'($urandom);
            case ($urandom_range(0, 9))
                0: w.op = 3'($urandom_range(6, 7));
                1: w.byte_count = 20'($urandom);
                2: w.end_address = 24'($urandom);
                3: w.address = 24'($urandom_range(0, FLASH_SIZE + 2));
                default: w.op = 3'($urandom_range(0, 5));
            endcase
            if (w.op == OP_RUN && w.byte_count > 20'd8)
                w.byte_count = 20'($urandom_range(0, 8));
            if (w.op == OP_CRC && w.end_address > w.address &&
                w.end_address - w.address > 24'd3)
                w.end_address = w.address + 24'd3;
            run_command(w, 400);
            k++;
        end
        w = cmd_word(OP_RUN, 24'd0, 20'd3, 24'd0, 2'd0, 1'b0);
        send_word(w);
        w.byte_count = 20'hFFFFF;
        run_command(w, 20);
        drain();
    endtask

    task automatic test_backpressure();
        hold_off = 200;
        repeat (30) tick_word();
        drain();
    endtask

    initial begin
        hold_off = 0;
        sent_count = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        seq_st = ST_IDLE; rx_byte = '0; bit_pos = '0; cur_addr = '0; stop_addr = '0;
        run_left = '0; crc_acc = '0; cur_op = '0; er_code = '0; er_poll = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

[sim.f]
hdl/sfce_pkg.sv
hdl/sfce_if.sv
hdl/sfce_seq.sv
hdl/spi_flash_command_engine_unit.sv
test/tb.sv
